// ===== sv/tga_rle_decoder_macros.svh =====
// Assertion macros shared by the Targa run-length decoder modules.
// Depends on nothing; the asserting modules provide clk and rst_n.
`ifndef TGA_RLE_DECODER_MACROS_SVH
`define TGA_RLE_DECODER_MACROS_SVH
`ifndef SYNTH
`define TGA_ASSERT_CLK(lbl, ck, rn, prop, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);
`define TGA_ASSERT(lbl, prop, msg) `TGA_ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`else
`define TGA_ASSERT_CLK(lbl, ck, rn, prop, msg)
`define TGA_ASSERT(lbl, prop, msg)
`endif
`endif

// ===== sv/tga_pkg.sv =====
// Types and constants for the Targa run-length decoder.
// Used by every module of the decoder; depends on nothing.
`timescale 1ns / 1ps

package tga_pkg;

    localparam int unsigned PIX_W   = 32;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CNT_W   = 8;
    localparam int unsigned BPP_W   = 3;
    localparam int unsigned CFG_IDX_W = 1;

    // Header byte fields.
    localparam logic [6:0] COUNT_MASK = 7'h7F;
    localparam int unsigned RUN_BIT = 7;

    // Pixel size code that selects four-byte pixels; anything else means three.
    localparam logic [BPP_W-1:0] WIDE_PIXEL = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_PIXEL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_COUNT     = 1'b1;

    // One decoded pixel together with its clipped repeat count.
    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic [CNT_W-1:0] count;
        logic             done;
    } cmd_t;

endpackage

// ===== sv/tga_front.sv =====
// Front end of the Targa decoder: configuration, header parsing and pixel assembly.
// Depends on tga_pkg; produces one command per completed pixel.
`timescale 1ns / 1ps

module tga_front
    import tga_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [PIX_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [BYTE_W-1:0]    in_byte,
    input  logic                 q_full,
    output logic                 q_push,
    output cmd_t                 q_data
);

    logic [BPP_W-1:0]  bpp_reg, bpp_next;
    logic [PIX_W-1:0]  pcount_reg, pcount_next;
    logic [CNT_W-1:0]  left_reg, left_next;
    logic              run_reg, run_next;
    logic [1:0]        bidx_reg, bidx_next;
    logic [PIX_W-1:0]  acc_reg, acc_next;
    logic [PIX_W-1:0]  emitted_reg, emitted_next;
    logic              done_reg, done_next;

    logic              accept;
    logic              wide;
    logic [PIX_W:0]    diff;
    logic [PIX_W-1:0]  avail;
    logic              img_full;
    logic [PIX_W-1:0]  acc_or;
    logic [2:0]        bidx_inc;
    logic [2:0]        size;
    logic [CNT_W-1:0]  n_raw;
    logic              avail_small;
    logic              clip;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign wide     = (bpp_reg == WIDE_PIXEL);
    assign size     = wide ? 3'd4 : 3'd3;
    assign bidx_inc = {1'b0, bidx_reg} + 3'd1;

    // Room left in the image; the borrow bit means it is already overfull.
    assign diff     = {1'b0, pcount_reg} - {1'b0, emitted_reg};
    assign avail    = diff[PIX_W-1:0];
    assign img_full = diff[PIX_W] || (avail == '0);

    assign n_raw       = run_reg ? left_reg : CNT_W'(1);
    assign avail_small = (avail[PIX_W-1:CNT_W] == '0);
    assign clip        = avail_small && (avail[CNT_W-1:0] < n_raw);

    always_comb
    begin
        acc_or = acc_reg;
        unique case (bidx_reg)
            2'd0: acc_or[7:0]   = acc_reg[7:0]   | in_byte;
            2'd1: acc_or[15:8]  = acc_reg[15:8]  | in_byte;
            2'd2: acc_or[23:16] = acc_reg[23:16] | in_byte;
            2'd3: acc_or[31:24] = acc_reg[31:24] | in_byte;
            default: acc_or = acc_reg;
        endcase
    end

    always_comb
    begin
        bpp_next     = bpp_reg;
        pcount_next  = pcount_reg;
        left_next    = left_reg;
        run_next     = run_reg;
        bidx_next    = bidx_reg;
        acc_next     = acc_reg;
        emitted_next = emitted_reg;
        done_next    = done_reg;
        q_push       = 1'b0;
        q_data.pix   = wide ? acc_or : {8'h00, acc_or[23:0]};
        q_data.count = clip ? avail[CNT_W-1:0] : n_raw;
        q_data.done  = avail_small && (avail[CNT_W-1:0] <= n_raw);

        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BYTES_PER_PIXEL: bpp_next    = cfg_data[BPP_W-1:0];
                CFG_PIXEL_COUNT:     pcount_next = cfg_data;
                default:             bpp_next    = bpp_reg;
            endcase
        end

        if (accept && !done_reg)
        begin
            priority if (img_full)
            begin
                done_next = 1'b1;
            end
            else if (left_reg == '0)
            begin
                left_next = {1'b0, in_byte[6:0] & COUNT_MASK} + CNT_W'(1);
                run_next  = in_byte[RUN_BIT];
                bidx_next = 2'd0;
                acc_next  = '0;
            end
            else if (bidx_inc < size)
            begin
                bidx_next = bidx_inc[1:0];
                acc_next  = acc_or;
            end
            else
            begin
                bidx_next    = 2'd0;
                acc_next     = '0;
                left_next    = run_reg ? '0 : left_reg - CNT_W'(1);
                // A clipped count lands exactly on the image size.
                emitted_next = clip ? pcount_reg : emitted_reg + PIX_W'(n_raw);
                done_next    = q_data.done;
                q_push       = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpp_reg     <= BPP_W'(3);
            pcount_reg  <= PIX_W'(1);
            left_reg    <= '0;
            run_reg     <= 1'b0;
            bidx_reg    <= 2'd0;
            acc_reg     <= '0;
            emitted_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            bpp_reg     <= bpp_next;
            pcount_reg  <= pcount_next;
            left_reg    <= left_next;
            run_reg     <= run_next;
            bidx_reg    <= bidx_next;
            acc_reg     <= acc_next;
            emitted_reg <= emitted_next;
            done_reg    <= done_next;
        end
    end

endmodule

// ===== sv/tga_cmdq.sv =====
// Short command queue between the decoder front and back ends.
// Depends on tga_pkg; the head entry is always entry zero.
`timescale 1ns / 1ps
`include "tga_rle_decoder_macros.svh"

module tga_cmdq
    import tga_pkg::*;
#(
    parameter int unsigned DEPTH = 2
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_data,
    input  logic pop,
    output cmd_t head,
    output logic full,
    output logic empty
);

    localparam int unsigned IDX_W = $clog2(DEPTH);
    localparam int unsigned CNT_W_Q = $clog2(DEPTH + 1);

    logic [CNT_W_Q-1:0] count_reg, count_next;
    logic [CNT_W_Q-1:0] after_pop;
    logic [IDX_W-1:0]   wr_idx;
    cmd_t               entry [DEPTH];

    assign full      = (count_reg == CNT_W_Q'(DEPTH));
    assign empty     = (count_reg == '0);
    assign head      = entry[0];
    assign after_pop = count_reg - CNT_W_Q'(pop);
    assign wr_idx    = after_pop[IDX_W-1:0];

    always_comb
    begin
        count_next = after_pop + CNT_W_Q'(push);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_entry
        cmd_t shift_in;
        if (i < DEPTH - 1)
        begin : g_mid
            assign shift_in = entry[i+1];
        end
        else
        begin : g_last
            assign shift_in = entry[i];
        end

        always_ff @(posedge clk)
        begin
            if (push && (wr_idx == IDX_W'(i)))
            begin
                entry[i] <= push_data;
            end
            else if (pop)
            begin
                entry[i] <= shift_in;
            end
        end
    end

    `TGA_ASSERT(a_no_overflow, push |-> (!full || pop), "push into a full command queue")
    `TGA_ASSERT(a_no_underflow, pop |-> !empty, "pop from an empty command queue")
    `TGA_ASSERT(a_count_range, count_reg <= CNT_W_Q'(DEPTH), "command queue count out of range")

endmodule

// ===== sv/tga_back.sv =====
// Back end of the Targa decoder: expands each command into pixel-pair beats.
// Depends on tga_pkg; drives the registered output channel.
`timescale 1ns / 1ps
`include "tga_rle_decoder_macros.svh"

module tga_back
    import tga_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cmd_t             q_head,
    input  logic             q_empty,
    output logic             q_pop,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [PIX_W-1:0] first_pixel,
    output logic [PIX_W-1:0] second_pixel,
    output logic             second_valid,
    output logic             run_end,
    output logic             image_done
);

    logic             active_reg, active_next;
    logic [CNT_W-1:0] left_reg, left_next;
    logic [PIX_W-1:0] pix_reg;
    logic             done_reg;
    logic             ov_reg, ov_next;
    logic [PIX_W-1:0] first_reg, second_reg;
    logic             sv_reg, re_reg, id_reg;

    logic advance;
    logic last;
    logic pair;

    assign advance = active_reg && (!ov_reg || out_ready);
    assign last    = (left_reg <= CNT_W'(2));
    assign pair    = (left_reg >= CNT_W'(2));
    assign q_pop   = !q_empty && (!active_reg || (advance && last));

    always_comb
    begin
        active_next = active_reg;
        left_next   = left_reg;
        if (q_pop)
        begin
            active_next = 1'b1;
            left_next   = q_head.count;
        end
        else if (advance)
        begin
            active_next = !last;
            left_next   = left_reg - CNT_W'(2);
        end
        ov_next = advance ? 1'b1 : (ov_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            left_reg   <= '0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            left_reg   <= left_next;
            ov_reg     <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            pix_reg  <= q_head.pix;
            done_reg <= q_head.done;
        end
        if (advance)
        begin
            first_reg  <= pix_reg;
            second_reg <= pair ? pix_reg : '0;
            sv_reg     <= pair;
            re_reg     <= last;
            id_reg     <= last && done_reg;
        end
    end

    assign out_valid    = ov_reg;
    assign first_pixel  = first_reg;
    assign second_pixel = second_reg;
    assign second_valid = sv_reg;
    assign run_end      = re_reg;
    assign image_done   = id_reg;

    `TGA_ASSERT(a_done_on_last, out_valid |-> (!image_done || run_end), "image_done without run_end")
    `TGA_ASSERT(a_second_zero, (out_valid && !second_valid) |-> (second_pixel == '0), "stray second pixel")
    `TGA_ASSERT(a_active_left, active_reg |-> (left_reg != '0), "active command with no pixels left")

endmodule

// ===== sv/tga_rle_decoder.sv =====
// Top level of the Targa run-length pixel stream decoder.
// Depends on tga_pkg, tga_front, tga_cmdq and tga_back.
`timescale 1ns / 1ps

// Channel  Direction  Handshake            Beat contents
// cfg      in         cfg_we               cfg_index, cfg_data (register write)
// in       in         in_valid / in_ready  in_byte, one stream byte
// out      out        out_valid/out_ready  two pixels, second_valid, run_end, image_done
//
// A closing run pixel gives ceil(n/2) output beats, one per cycle while out_ready is
// high; the byte stream stalls only when the command queue of QUEUE_DEPTH entries
// is full.
// Reset clears all parsing state; configuration returns to 3-byte pixels, one pixel.
// Output stalls hold the output register and back end without touching the front.

module tga_rle_decoder
    import tga_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 2
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [PIX_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [BYTE_W-1:0]    in_byte,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [PIX_W-1:0]     first_pixel,
    output logic [PIX_W-1:0]     second_pixel,
    output logic                 second_valid,
    output logic                 run_end,
    output logic                 image_done
);

    // Commands carry a finished pixel with its repeat count, already cut to
    // the pixels the image still needs, and a flag for the image's last pixel.
    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;
    cmd_t q_in;
    cmd_t q_head;

    // The front end parses headers, assembles pixels and counts the image.
    tga_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_byte   (in_byte),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_in)
    );

    // The queue lets the front keep taking bytes while a run is expanded.
    tga_cmdq #(
        .DEPTH (QUEUE_DEPTH)
    ) u_cmdq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .head      (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    // The back end turns each command into pixel-pair beats.
    tga_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_head       (q_head),
        .q_empty      (q_empty),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .first_pixel  (first_pixel),
        .second_pixel (second_pixel),
        .second_valid (second_valid),
        .run_end      (run_end),
        .image_done   (image_done)
    );

endmodule

// ===== verif/tb_tga_rle_decoder.sv =====
// Self-checking testbench for the Targa run-length pixel stream decoder.
// Depends on tga_pkg and tga_rle_decoder; a built-in predictor checks every output beat.
`timescale 1ns / 1ps

module tb_tga_rle_decoder;
    import tga_pkg::*;

    // Cycles with no beat on either channel before the run is declared hung. The longest
    // honest silence is the deliberate receiver hold-off, well under this figure.
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    // Quiet cycles allowed after the last expected beat before a register is touched,
    // so that a byte still working its way through the front end has settled.
    localparam int unsigned SETTLE_CYCLES  = 20;
    localparam int unsigned RANDOM_BYTES   = 280;
    localparam int unsigned SQUEEZE_CYCLES = 250;
    // Largest image: 65535 by 65535 pixels.
    localparam logic [PIX_W-1:0] MAX_PIXELS = 32'hFFFE_0001;

    // One output beat as the decoder should present it.
    typedef struct {
        logic [PIX_W-1:0] first_px;
        logic [PIX_W-1:0] second_px;
        logic             has_second;
        logic             last;
        logic             done;
    } pixel_pair_t;

    // Rows of the directed table: a stream byte or a register write.
    typedef enum logic [1:0] {
        ROW_BYTE,
        ROW_BPP,
        ROW_COUNT
    } row_kind_t;

    typedef struct {
        row_kind_t        kind;
        logic [PIX_W-1:0] value;
        bit               fixed;
        pixel_pair_t      want;
    } stim_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [PIX_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic [BYTE_W-1:0]    in_byte;
    logic                 out_valid;
    logic                 out_ready;
    logic [PIX_W-1:0]     first_pixel;
    logic [PIX_W-1:0]     second_pixel;
    logic                 second_valid;
    logic                 run_end;
    logic                 image_done;

    // Predictor state, kept in step with the decoder one accepted byte at a time.
    logic [BPP_W-1:0] bpp_code;
    logic [PIX_W-1:0] total_px;
    logic [CNT_W-1:0] pkt_left;
    logic             run_pkt;
    logic [1:0]       byte_pos;
    logic [PIX_W-1:0] acc;
    logic [PIX_W-1:0] emitted;
    logic             img_finished;

    pixel_pair_t fresh_pairs[$];
    pixel_pair_t pending_pairs[$];
    pixel_pair_t no_pair;
    pixel_pair_t head;
    stim_row_t   plan[$];

    int unsigned mismatches;
    int unsigned idle_cycles;
    int unsigned stall_left;
    int unsigned random_sent;
    bit          calm;
    bit          squeeze_req;
    bit          squeeze_done;

    tga_rle_decoder DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_byte      (in_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .first_pixel  (first_pixel),
        .second_pixel (second_pixel),
        .second_valid (second_valid),
        .run_end      (run_end),
        .image_done   (image_done)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Works out the beats that one accepted stream byte gives and leaves them in
    // fresh_pairs. A header only loads the packet; a pixel byte only counts until the
    // pixel closes, and a closing run pixel is spread over pairs, clipped to the image.
    function automatic void decode_byte(input logic [BYTE_W-1:0] b);
        int unsigned size;
        int unsigned pos;
        int unsigned avail;
        int unsigned n;
        int unsigned pairs;
        int unsigned i;
        logic [PIX_W-1:0] pix;
        pixel_pair_t pp;
        fresh_pairs.delete();
        if (img_finished)
            return;
        // An image that is already full swallows the byte and closes for good.
        if (emitted >= total_px)
        begin
            img_finished = 1'b1;
            return;
        end
        if (pkt_left == 0)
        begin
            pkt_left = {1'b0, b[6:0] & COUNT_MASK} + 8'd1;
            run_pkt  = b[RUN_BIT];
            byte_pos = 2'd0;
            acc      = '0;
            return;
        end
        // Any size code other than the wide one means three bytes, and the size is read
        // afresh on every byte, so a change in mid-pixel takes effect at once.
        size = (bpp_code == WIDE_PIXEL) ? 4 : 3;
        pos  = 32'(byte_pos);
        acc  = acc | ({24'd0, b} << (8 * pos));
        if (pos + 1 < size)
        begin
            byte_pos = byte_pos + 2'd1;
            return;
        end
        pix      = (size == 3) ? (acc & 32'h00FF_FFFF) : acc;
        byte_pos = 2'd0;
        acc      = '0;
        avail    = total_px - emitted;
        if (run_pkt)
        begin
            n        = 32'(pkt_left);
            pkt_left = '0;
        end
        else
        begin
            n        = 1;
            pkt_left = pkt_left - 8'd1;
        end
        if (n > avail)
            n = avail;
        emitted = emitted + n;
        if (emitted >= total_px)
            img_finished = 1'b1;
        pairs = (n + 1) / 2;
        for (i = 0; i < pairs; i++)
        begin
            pp.first_px   = pix;
            pp.has_second = (2 * i + 1 < n);
            pp.second_px  = pp.has_second ? pix : '0;
            pp.last       = (i + 1 == pairs);
            pp.done       = pp.last & img_finished;
            fresh_pairs   = {fresh_pairs, pp};
        end
    endfunction

    // Mostly back-to-back, sometimes a short gap, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (calm)
            return 0;
        r = $urandom_range(0, 19);
        if (r < 12)
            return 0;
        if (r < 18)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void add_row(input stim_row_t row);
        plan = {plan, row};
    endfunction

    function automatic stim_row_t row_byte(input logic [BYTE_W-1:0] b);
        stim_row_t row;
        row.kind  = ROW_BYTE;
        row.value = {24'd0, b};
        row.fixed = 1'b0;
        row.want  = no_pair;
        return row;
    endfunction

    // A byte whose single beat is written out by hand; it is always the last of its
    // run and never the end of the image.
    function automatic stim_row_t row_fixed(input logic [BYTE_W-1:0] b,
                                            input logic [PIX_W-1:0] first_px,
                                            input logic [PIX_W-1:0] second_px,
                                            input logic has_second);
        stim_row_t row;
        row.kind            = ROW_BYTE;
        row.value           = {24'd0, b};
        row.fixed           = 1'b1;
        row.want.first_px   = first_px;
        row.want.second_px  = second_px;
        row.want.has_second = has_second;
        row.want.last       = 1'b1;
        row.want.done       = 1'b0;
        return row;
    endfunction

    function automatic stim_row_t row_cfg(input row_kind_t kind, input logic [PIX_W-1:0] value);
        stim_row_t row;
        row.kind  = kind;
        row.value = value;
        row.fixed = 1'b0;
        row.want  = no_pair;
        return row;
    endfunction

    task automatic flag_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    // Offers one byte after a random gap and holds it until the beat is taken. The
    // valid is raised at the same falling edge it would otherwise be dropped at, so a
    // back-to-back byte never sees two assignments in one step.
    task automatic send_byte(input logic [BYTE_W-1:0] b, input bit fixed,
                             input pixel_pair_t want);
        int unsigned gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        decode_byte(b);
        if (fixed)
            pending_pairs = {pending_pairs, want};
        else
            pending_pairs = {pending_pairs, fresh_pairs};
    endtask

    // Stops offering, waits for every expected beat, then lets the block go quiet.
    task automatic drain_block();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_pairs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register writes happen only on an idle block.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PIX_W-1:0] data);
        drain_block();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_BYTES_PER_PIXEL)
            bpp_code = data[BPP_W-1:0];
        else
            total_px = data;
    endtask

    // Picks a pixel size, mostly a legal one, with random junk above the size field.
    task automatic retune_size();
        logic [PIX_W-1:0] data;
        int unsigned r;
        data = $urandom();
        r    = $urandom_range(0, 5);
        if (r < 2)
            data[BPP_W-1:0] = WIDE_PIXEL;
        else if (r < 4)
            data[BPP_W-1:0] = 3'd3;
        else
            data[BPP_W-1:0] = 3'($urandom());
        write_reg(CFG_BYTES_PER_PIXEL, data);
    endtask

    // One well-formed packet: a header, then pixel bytes until the predictor sees the
    // packet close. Runs are now and then long, literals mostly short to keep the byte budget.
    // Once in a while the pixel size is changed between two bytes of a pixel, but never
    // while the receiver is holding off, so that the sender keeps pushing bytes then.
    task automatic send_random_packet();
        bit is_run;
        int unsigned cnt;
        int unsigned r;
        logic [BYTE_W-1:0] hdr;
        logic [BYTE_W-1:0] b;
        is_run = 1'($urandom_range(0, 1));
        r      = $urandom_range(0, 9);
        if (is_run)
            cnt = (r == 0) ? $urandom_range(64, 128) : $urandom_range(1, 12);
        else
            cnt = (r == 0) ? $urandom_range(16, 40) : $urandom_range(1, 6);
        hdr          = 8'(cnt - 1);
        hdr[RUN_BIT] = is_run;
        send_byte(hdr, 1'b0, no_pair);
        random_sent++;
        while (pkt_left != 0 && !img_finished)
        begin
            if (stall_left == 0 && $urandom_range(0, 39) == 0)
                retune_size();
            r = $urandom_range(0, 7);
            if (r == 0)
                b = 8'h00;
            else if (r == 1)
                b = 8'hFF;
            else
                b = 8'($urandom());
            send_byte(b, 1'b0, no_pair);
            random_sent++;
        end
    endtask

    // Receiver: random stalls at every falling edge, plus one long hold-off asked for
    // by the main sequence and counted here, during which the sender keeps offering.
    always @(negedge clk)
    begin
        if (squeeze_req && !squeeze_done)
        begin
            stall_left   = SQUEEZE_CYCLES;
            squeeze_done = 1'b1;
        end
        if (stall_left != 0)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            out_ready <= 1'b1;
            if (!calm && $urandom_range(0, 3) == 0)
                stall_left = pick_gap();
        end
    end

    // Every output beat is checked, field by field, against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_pairs.size() == 0)
                flag_mismatch($sformatf("beat with nothing expected: %h %h",
                                        first_pixel, second_pixel));
            else
            begin
                head = pending_pairs.pop_front();
                if (first_pixel !== head.first_px)
                    flag_mismatch($sformatf("first_pixel %h, wanted %h",
                                            first_pixel, head.first_px));
                if (second_pixel !== head.second_px)
                    flag_mismatch($sformatf("second_pixel %h, wanted %h",
                                            second_pixel, head.second_px));
                if (second_valid !== head.has_second)
                    flag_mismatch($sformatf("second_valid %b, wanted %b",
                                            second_valid, head.has_second));
                if (run_end !== head.last)
                    flag_mismatch($sformatf("run_end %b, wanted %b", run_end, head.last));
                if (image_done !== head.done)
                    flag_mismatch($sformatf("image_done %b, wanted %b",
                                            image_done, head.done));
            end
        end
    end

    // Watchdog: any beat on either channel restarts the count.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial
    begin
        int unsigned i;
        int unsigned k;

        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        in_byte      = '0;
        out_ready    = 1'b0;
        mismatches   = 0;
        idle_cycles  = 0;
        stall_left   = 0;
        random_sent  = 0;
        calm         = 1'b0;
        squeeze_req  = 1'b0;
        squeeze_done = 1'b0;
        no_pair      = '{default: '0};

        // Predictor reset: three-byte pixels, an image of one pixel, expecting a header.
        bpp_code     = 3'd3;
        total_px     = 32'd1;
        pkt_left     = '0;
        run_pkt      = 1'b0;
        byte_pos     = 2'd0;
        acc          = '0;
        emitted      = '0;
        img_finished = 1'b0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part. The image is made as large as it can be first, since the reset
        // size of one pixel would close the image on the first pixel.
        add_row(row_cfg(ROW_COUNT, MAX_PIXELS));
        // A literal packet of one all-ones pixel.
        add_row(row_byte(8'h00));
        add_row(row_byte(8'hFF));
        add_row(row_byte(8'hFF));
        add_row(row_fixed(8'hFF, 32'h00FF_FFFF, 32'h0, 1'b0));
        // A run of one all-zero pixel: an odd count leaves the second slot empty.
        add_row(row_byte(8'h80));
        add_row(row_byte(8'h00));
        add_row(row_byte(8'h00));
        add_row(row_fixed(8'h00, 32'h0, 32'h0, 1'b0));
        // The longest run, 128 copies, which gives the longest train of beats.
        add_row(row_byte(8'hFF));
        add_row(row_byte(8'h12));
        add_row(row_byte(8'h34));
        add_row(row_byte(8'h56));
        // Four-byte pixels, a literal packet of two.
        add_row(row_cfg(ROW_BPP, {29'd0, WIDE_PIXEL}));
        add_row(row_byte(8'h01));
        add_row(row_byte(8'h11));
        add_row(row_byte(8'h22));
        add_row(row_byte(8'h33));
        add_row(row_fixed(8'h44, 32'h4433_2211, 32'h0, 1'b0));
        add_row(row_byte(8'hA5));
        add_row(row_byte(8'h5A));
        add_row(row_byte(8'hC3));
        // The size drops to three with three bytes already in: the next byte closes the
        // pixel and its top byte is cleared.
        add_row(row_cfg(ROW_BPP, 32'd3));
        add_row(row_fixed(8'h3C, 32'h00C3_5AA5, 32'h0, 1'b0));
        // An odd size code behaves as three; a run of two fills one beat.
        add_row(row_cfg(ROW_BPP, 32'd7));
        add_row(row_byte(8'h81));
        add_row(row_byte(8'h01));
        add_row(row_byte(8'h02));
        add_row(row_fixed(8'h03, 32'h0003_0201, 32'h0003_0201, 1'b1));

        for (i = 0; i < plan.size(); i++)
        begin
            case (plan[i].kind)
                ROW_BYTE:  send_byte(plan[i].value[BYTE_W-1:0], plan[i].fixed, plan[i].want);
                ROW_BPP:   write_reg(CFG_BYTES_PER_PIXEL, plan[i].value);
                ROW_COUNT: write_reg(CFG_PIXEL_COUNT, plan[i].value);
                default:   flag_mismatch("bad directed row");
            endcase
        end

        // Random part. It opens with the long receiver hold-off so that the command
        // queue fills and the byte stream backs up behind it. No register write or
        // drain is started while the receiver holds off.
        retune_size();
        squeeze_req = 1'b1;
        wait (squeeze_done);
        while (random_sent < RANDOM_BYTES)
        begin
            if ($urandom_range(0, 7) == 0)
                calm = !calm;
            k = (stall_left == 0) ? $urandom_range(0, 19) : 19;
            if (k == 0)
                retune_size();
            else if (k == 1)
                write_reg(CFG_PIXEL_COUNT, $urandom() | 32'h8000_0000);
            else if (k == 2)
                drain_block();
            send_random_packet();
        end
        calm = 1'b0;

        // Closing the image is final until reset, so only one way of closing it can be
        // taken per run; the seed picks between them.
        if ($urandom_range(0, 1) == 1)
        begin
            // Three pixels left: a run is cut short, and the last beat carries one pixel
            // and the end-of-image flag.
            write_reg(CFG_PIXEL_COUNT, emitted + 32'd3);
            while (!img_finished)
            begin
                if (pkt_left == 0)
                    send_byte(8'h85, 1'b0, no_pair);
                else
                    send_byte(8'($urandom()), 1'b0, no_pair);
            end
        end
        else
        begin
            // The image size is lowered to what is already out: the next byte finds the
            // image full, is dropped and closes the image without a beat.
            write_reg(CFG_PIXEL_COUNT, emitted);
            send_byte(8'($urandom()), 1'b0, no_pair);
        end

        // Once closed, nothing comes out whatever follows, even at the smallest size.
        write_reg(CFG_PIXEL_COUNT, 32'd1);
        send_byte(8'hFF, 1'b0, no_pair);
        send_byte(8'h00, 1'b0, no_pair);
        for (i = 0; i < 6; i++)
            send_byte(8'($urandom()), 1'b0, no_pair);

        drain_block();
        repeat (2 * SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
